// ===== hdl/int8_matrix_multiply_macros.svh =====
// Assertion macros shared by the int8 matrix multiply RTL.
`ifndef INT8_MATRIX_MULTIPLY_MACROS_SVH
`define INT8_MATRIX_MULTIPLY_MACROS_SVH

// Checks that expr holds in the same cycle as cond.
`define IMM_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Checks that expr holds in the cycle after cond.
`define IMM_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/imm_pkg.sv =====
// Package with the types, codes and constants of the int8 matrix multiply.
package imm_pkg;

   localparam int DIM_DEFAULT = 128;
   localparam int FUNC_W      = 2;
   localparam int IDX_W       = 7;
   localparam int ELEM_W      = 8;
   localparam int ACC_W       = 16;

   typedef logic [FUNC_W-1:0]        func_bits_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_A = 2'd0,
      FUNC_WRITE_B = 2'd1,
      FUNC_READ_C  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic en;
   } mac_ctl_type;

endpackage

// ===== hdl/imm_channels.sv =====
// Interfaces for the request and response channels of the matrix multiply.
interface imm_req_if;
   logic                    valid;
   logic                    ready;
   imm_pkg::func_bits_type  func;
   imm_pkg::idx_type        row;
   imm_pkg::idx_type        col;
   imm_pkg::elem_type       element_value;

   modport source (output valid, func, row, col, element_value, input ready);
   modport sink (input valid, func, row, col, element_value, output ready);
endinterface

interface imm_rsp_if;
   logic              valid;
   logic              ready;
   imm_pkg::acc_type  c_value;

   modport source (output valid, c_value, input ready);
   modport sink (input valid, c_value, output ready);
endinterface

// ===== hdl/int8_matrix_multiply.sv =====
// Top level of the signed 8-bit square matrix multiply with element addressing.
//
// The request channel carries one item per handshake: func selects a write of
// one element of A, a write of one element of B, or a read of C(row, col).
// Writes give no response, and other func codes are ignored. A read gives one response item
// holding the 16-bit wrapped dot product of row 'row' of A and column 'col' of
// B, or zero when row or col is at or beyond DIM.
// A read walks DIM products through one shared multiply-accumulate fed by two
// registered-read memories, then passes a drain state and a finish state, where
// its result is loaded into the output register; the request channel is not
// ready from acceptance until that load. A read with row or col at or beyond
// DIM skips the walk and goes straight to the finish state.
// Reset clears the sequencer and the response valid; matrix contents are
// undefined until written, and no clearing pass is run.
// The response sits in an output register. Writes are still taken while it
// waits; a following read finishes its walk and then holds until the
// receiver has taken the earlier response.
`include "int8_matrix_multiply_macros.svh"

module int8_matrix_multiply #(
   parameter int DIM = imm_pkg::DIM_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   imm_req_if.sink   req_chan,
   imm_rsp_if.source rsp_chan
);
   import imm_pkg::*;

   localparam int DEPTH  = DIM * DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic               a_wr_en;
   logic               b_wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   elem_type           wr_data;
   logic [ADDR_W-1:0]  a_rd_addr;
   logic [ADDR_W-1:0]  b_rd_addr;
   elem_type           a_data;
   elem_type           b_data;
   mac_ctl_type        mac_ctl;
   acc_type            acc;
   logic               load_out;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   acc_type            c_value_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   imm_ctrl #(
      .DIM    (DIM),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_free  (out_free),
      .a_wr_en   (a_wr_en),
      .b_wr_en   (b_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .mac_ctl   (mac_ctl),
      .load_out  (load_out)
   );

   imm_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_a_mem (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   imm_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_b_mem (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   imm_mac u_mac (
      .clock   (clock),
      .mac_ctl (mac_ctl),
      .a_data  (a_data),
      .b_data  (b_data),
      .acc     (acc)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         c_value_ff <= acc;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.c_value = c_value_ff;

   `IMM_ASSERT_SAME(a_no_overwrite, clock, reset, load_out, out_free, "response overwritten")
   `IMM_ASSERT_NEXT(a_load_sets_valid, clock, reset, load_out, rsp_valid_ff, "valid not set")
   `IMM_ASSERT_SAME(a_busy_while_mac, clock, reset, mac_ctl.en, !req_chan.ready, "ready in walk")
   `IMM_ASSERT_SAME(a_single_write, clock, reset, a_wr_en, !b_wr_en && req_chan.ready, "stray write")
endmodule

// ===== hdl/imm_mem.sv =====
// Single-port-write, registered-read element memory for one matrix.
module imm_mem #(
   parameter int DEPTH  = imm_pkg::DIM_DEFAULT * imm_pkg::DIM_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  imm_pkg::elem_type   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output imm_pkg::elem_type   rd_data
);
   import imm_pkg::*;

   elem_type mem_ff [DEPTH];
   elem_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/imm_mac.sv =====
// Shared signed 8-bit multiply with a wrapping 16-bit accumulator.
module imm_mac (
   input  logic                  clock,
   input  imm_pkg::mac_ctl_type  mac_ctl,
   input  imm_pkg::elem_type     a_data,
   input  imm_pkg::elem_type     b_data,
   output imm_pkg::acc_type      acc
);
   import imm_pkg::*;

   acc_type acc_ff;
   acc_type acc_in;
   acc_type product;

   assign product = acc_type'(a_data) * acc_type'(b_data);

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (mac_ctl.en) begin
         acc_in = acc_ff + product;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ===== hdl/imm_ctrl.sv =====
// Sequencer that takes items, writes the matrices and steps the dot product.
module imm_ctrl #(
   parameter int DIM    = imm_pkg::DIM_DEFAULT,
   parameter int ADDR_W = $clog2(DIM * DIM)
) (
   input  logic                  clock,
   input  logic                  reset,
   imm_req_if.sink               req_chan,
   input  logic                  out_free,
   output logic                  a_wr_en,
   output logic                  b_wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output imm_pkg::elem_type     wr_data,
   output logic [ADDR_W-1:0]     a_rd_addr,
   output logic [ADDR_W-1:0]     b_rd_addr,
   output imm_pkg::mac_ctl_type  mac_ctl,
   output logic                  load_out
);
   import imm_pkg::*;

   localparam int K_W = (DIM > 1) ? $clog2(DIM) : 1;

   state_type          state_ff, state_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0]  a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]  b_addr_ff, b_addr_in;
   logic               issue_ff, issue_in;
   logic               in_range;

   assign in_range = (32'(req_chan.row) < DIM) && (32'(req_chan.col) < DIM);
   assign wr_addr  = ADDR_W'(req_chan.row) * ADDR_W'(DIM) + ADDR_W'(req_chan.col);
   assign wr_data  = req_chan.element_value;
   assign a_rd_addr = a_addr_ff;
   assign b_rd_addr = b_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      a_addr_in      = a_addr_ff;
      b_addr_in      = b_addr_ff;
      issue_in       = 1'b0;
      req_chan.ready = 1'b0;
      a_wr_en        = 1'b0;
      b_wr_en        = 1'b0;
      mac_ctl.clear  = 1'b0;
      mac_ctl.en     = issue_ff;
      load_out       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               case (func_type'(req_chan.func))
                  FUNC_WRITE_A: begin
                     a_wr_en = in_range;
                  end
                  FUNC_WRITE_B: begin
                     b_wr_en = in_range;
                  end
                  FUNC_READ_C: begin
                     mac_ctl.clear = 1'b1;
                     k_in      = '0;
                     a_addr_in = ADDR_W'(req_chan.row) * ADDR_W'(DIM);
                     b_addr_in = ADDR_W'(req_chan.col);
                     state_in  = in_range ? ST_RUN : ST_FINISH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            issue_in  = 1'b1;
            k_in      = k_ff + K_W'(1);
            a_addr_in = a_addr_ff + ADDR_W'(1);
            b_addr_in = b_addr_ff + ADDR_W'(DIM);
            if (k_ff == K_W'(DIM - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
